FILE: src/uvs_pkg.sv
// Shared types, constants and arithmetic helpers for the UV sphere mesh generator.
// No dependencies; the files that use it refer to it by scoped names.
package uvs_pkg;

    // CORDIC set-up: rotations, gain in Q2.30, datapath widths
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_DIAMETER = 2'd0;
    localparam logic [1:0] REG_LAT_DIV  = 2'd1;
    localparam logic [1:0] REG_LON_DIV  = 2'd2;

    localparam logic [15:0] DIAMETER_RESET = 16'd256;
    localparam logic [8:0]  LAT_DIV_RESET  = 9'd8;
    localparam logic [8:0]  LON_DIV_RESET  = 9'd8;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI    = 1'b1;

    typedef enum logic [1:0] {
        PH_NORTH,
        PH_RING,
        PH_SOUTH,
        PH_TRI
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROT,
        ST_MULN,
        ST_NORM,
        ST_MULP,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic div_start;
        logic rot_start;
        logic load_pole;
        logic south;
        logic mul_norm;
        logic load_norm;
        logic mul_pos;
        logic emit;
        logic emit_tri;
        logic last;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic rot_done;
        logic slot_free;
    } dp_stat_t;

    // atan(2^-k) as a fraction of a 32-bit turn
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [31:0] a;
        case (k)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // Right shift by n, rounding half away from zero
    function automatic logic signed [39:0] round_away(input logic signed [39:0] v,
                                                      input int unsigned n);
        logic signed [39:0] half;
        logic signed [39:0] mag;
        logic signed [39:0] r;
        half = 40'sd1 <<< (n - 1);
        mag  = v[39] ? -v : v;
        r    = (mag + half) >>> n;
        return v[39] ? -r : r;
    endfunction

    function automatic logic signed [15:0] clamp_unit(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd16384)
            r = UNIT_Q14;
        else if (v < -40'sd16384)
            r = -UNIT_Q14;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

FILE: src/uvs_if.sv
// Handshake channels of the UV sphere mesh generator: request, element and config write.
// Depends on nothing.
interface uvs_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface uvs_elem_if;
    logic               valid;
    logic               ready;
    logic               element_kind;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        corner_a;
    logic [15:0]        corner_b;
    logic [15:0]        corner_c;
    logic               mesh_done;

    modport source (output valid, output element_kind, output pos_x, output pos_y,
                    output pos_z, output norm_x, output norm_y, output norm_z,
                    output corner_a, output corner_b, output corner_c,
                    output mesh_done, input ready);
    modport sink   (input valid, input element_kind, input pos_x, input pos_y,
                    input pos_z, input norm_x, input norm_y, input norm_z,
                    input corner_a, input corner_b, input corner_c,
                    input mesh_done, output ready);
endinterface

interface uvs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/uv_sphere_mesh_generator.sv
// Top level of the UV sphere mesh generator: sequencer plus vertex datapath.
// Depends on uvs_pkg, uvs_if, uvs_ctrl, uvs_dp.
//
//   channel  role    payload
//   req      sink    restart
//   elem     source  element_kind, pos_x/y/z, norm_x/y/z, corner_a/b/c, mesh_done
//   cfg      sink    index, data (diameter, latitude_divisions, longitude_divisions)
//
// One item at a time. A ring vertex passes through the bit-serial angle dividers, the
// 20-rotation CORDIC pair, the normal multiply and rounding and the position multiply
// before it is loaded into the result register; a pole vertex needs only the position
// multiply, a triangle goes straight to emit, and req.ready is back the cycle after the load.
// The result register lets the next item be accepted while an element waits on
// elem.ready; a stall holds only the emit step.
// rst_n clears the sequencer and configuration at once; no clearing pass.
module uv_sphere_mesh_generator #(
    parameter int MAX_DIVISIONS = 256,
    parameter int ANGLE_BITS    = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    uvs_req_if.sink    req,
    uvs_elem_if.source elem,
    uvs_cfg_if.sink    cfg
);
    localparam int DIV_W = $clog2(MAX_DIVISIONS + 1);

    uvs_pkg::dp_cmd_t  cmd;
    uvs_pkg::dp_stat_t stat;

    logic [DIV_W-1:0] col_op, band_op, lon_op, lat_op;
    logic [15:0]      diameter_op;
    logic [15:0]      corner_a_op, corner_b_op, corner_c_op;

    uvs_ctrl #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg         (cfg),
        .cmd         (cmd),
        .stat        (stat),
        .col_op      (col_op),
        .band_op     (band_op),
        .lon_op      (lon_op),
        .lat_op      (lat_op),
        .diameter_op (diameter_op),
        .corner_a_op (corner_a_op),
        .corner_b_op (corner_b_op),
        .corner_c_op (corner_c_op)
    );

    uvs_dp #(.MAX_DIVISIONS(MAX_DIVISIONS), .ANGLE_BITS(ANGLE_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .col_op      (col_op),
        .band_op     (band_op),
        .lon_op      (lon_op),
        .lat_op      (lat_op),
        .diameter_op (diameter_op),
        .corner_a_op (corner_a_op),
        .corner_b_op (corner_b_op),
        .corner_c_op (corner_c_op),
        .elem        (elem)
    );

endmodule

FILE: src/uvs_div.sv
// Restoring divider, one quotient bit per cycle; keeps the low QW quotient bits.
// Depends on nothing.
module uvs_div #(
    parameter int NB = 25,
    parameter int DW = 9,
    parameter int QW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NB-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quot
);
    localparam int CNT_W = $clog2(NB + 1);

    logic [NB-1:0]    num_reg, num_next;
    logic [DW-1:0]    den_reg;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DW:0] trial;
    logic        fits;

    always_comb
    begin
        trial     = {rem_reg, num_reg[NB-1]};
        fits      = trial >= {1'b0, den_reg};
        rem_next  = fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
        quot_next = {quot_reg[QW-2:0], fits};
        num_next  = {num_reg[NB-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NB);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: src/uvs_cordic.sv
// Iterative CORDIC: cos and sin of a turn-fraction angle, Q1.14, one rotation per cycle.
// Depends on uvs_pkg.
module uvs_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic                  done,
    output logic signed [15:0]    cos_q14,
    output logic signed [15:0]    sin_q14
);
    localparam int XY_W = uvs_pkg::XY_W;
    localparam int Z_W  = uvs_pkg::Z_W;
    localparam int SW   = uvs_pkg::STEP_W;

    logic [31:0]            ang32;
    logic [31:0]            ang_shift;
    logic [1:0]             quad;
    logic [31:0]            rest;

    logic signed [XY_W-1:0] x_reg, x_next;
    logic signed [XY_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [SW-1:0]          k_reg;
    logic [1:0]             quad_reg;
    logic                   run_reg;
    logic                   fin_reg;
    logic                   done_reg;
    logic signed [15:0]     cos_reg, cos_next;
    logic signed [15:0]     sin_reg, sin_next;

    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  step_ang;
    logic signed [15:0]     c, s;

    // reduce to the nearest quadrant, leaving a residual within an eighth of a turn
    always_comb
    begin
        ang32     = {angle, {(32 - ANGLE_BITS){1'b0}}};
        ang_shift = ang32 + 32'h2000_0000;
        quad      = ang_shift[31:30];
        rest      = ang32 - {quad, 30'd0};
    end

    always_comb
    begin
        dx       = y_reg >>> k_reg;
        dy       = x_reg >>> k_reg;
        step_ang = $signed({1'b0, uvs_pkg::atan_turn(k_reg)});
        if (!z_reg[Z_W-1])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - step_ang;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + step_ang;
        end
    end

    always_comb
    begin
        c = uvs_pkg::clamp_unit(uvs_pkg::round_away(40'(x_reg), 16));
        s = uvs_pkg::clamp_unit(uvs_pkg::round_away(40'(y_reg), 16));
        case (quad_reg)
            2'd0:
            begin
                cos_next = c;
                sin_next = s;
            end
            2'd1:
            begin
                cos_next = -s;
                sin_next = c;
            end
            2'd2:
            begin
                cos_next = -c;
                sin_next = -s;
            end
            default:
            begin
                cos_next = s;
                sin_next = -c;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (run_reg)
        begin
            k_reg <= k_reg + 1'b1;
            if (k_reg == SW'(uvs_pkg::CORDIC_STEPS - 1))
            begin
                run_reg <= 1'b0;
                fin_reg <= 1'b1;
            end
        end
        else if (fin_reg)
        begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= uvs_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({rest[31], rest});
            quad_reg <= quad;
        end
        else if (run_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (fin_reg)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign done    = done_reg;
    assign cos_q14 = cos_reg;
    assign sin_q14 = sin_reg;

endmodule

FILE: src/uvs_dp.sv
// Vertex datapath: angle dividers, two CORDIC units, normal and position multipliers,
// and the element output register. Depends on uvs_pkg, uvs_if, uvs_div, uvs_cordic.
module uvs_dp #(
    parameter int MAX_DIVISIONS = 256,
    parameter int ANGLE_BITS    = 16,
    localparam int DIV_W        = $clog2(MAX_DIVISIONS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  uvs_pkg::dp_cmd_t      cmd,
    output uvs_pkg::dp_stat_t     stat,
    input  logic [DIV_W-1:0]      col_op,
    input  logic [DIV_W-1:0]      band_op,
    input  logic [DIV_W-1:0]      lon_op,
    input  logic [DIV_W-1:0]      lat_op,
    input  logic [15:0]           diameter_op,
    input  logic [15:0]           corner_a_op,
    input  logic [15:0]           corner_b_op,
    input  logic [15:0]           corner_c_op,
    uvs_elem_if.source            elem
);
    localparam int NB = DIV_W + ANGLE_BITS;

    logic [NB-1:0]         lon_num, col_num;
    logic [ANGLE_BITS-1:0] lon_ang, col_ang;
    logic                  lon_div_done, col_div_done;
    logic                  lon_rot_done, col_rot_done;
    logic signed [15:0]    cos_lon, sin_lon, cos_col, sin_col;

    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic signed [32:0] qx_reg, qy_reg, qz_reg;
    logic signed [16:0] diam_s;

    logic signed [39:0] rx, ry, rz;

    logic               valid_reg;
    logic               kind_reg;
    logic signed [16:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [15:0] norm_x_reg, norm_y_reg, norm_z_reg;
    logic [15:0]        corner_a_reg, corner_b_reg, corner_c_reg;
    logic               done_reg;

    assign lon_num = {col_op, {ANGLE_BITS{1'b0}}};
    assign col_num = {1'b0, band_op, {(ANGLE_BITS - 1){1'b0}}};

    uvs_div #(.NB(NB), .DW(DIV_W), .QW(ANGLE_BITS)) u_div_lon (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (lon_num),
        .den   (lon_op),
        .done  (lon_div_done),
        .quot  (lon_ang)
    );

    uvs_div #(.NB(NB), .DW(DIV_W), .QW(ANGLE_BITS)) u_div_col (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (col_num),
        .den   (lat_op),
        .done  (col_div_done),
        .quot  (col_ang)
    );

    uvs_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_lon (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.rot_start),
        .angle   (lon_ang),
        .done    (lon_rot_done),
        .cos_q14 (cos_lon),
        .sin_q14 (sin_lon)
    );

    uvs_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_col (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.rot_start),
        .angle   (col_ang),
        .done    (col_rot_done),
        .cos_q14 (cos_col),
        .sin_q14 (sin_col)
    );

    assign diam_s = $signed({1'b0, diameter_op});

    always_comb
    begin
        rx = uvs_pkg::round_away(40'(qx_reg), 15);
        ry = uvs_pkg::round_away(40'(qy_reg), 15);
        rz = uvs_pkg::round_away(40'(qz_reg), 15);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_norm)
        begin
            px_reg <= 32'(cos_lon) * 32'(sin_col);
            py_reg <= 32'(sin_lon) * 32'(sin_col);
        end
        if (cmd.load_norm)
        begin
            nx_reg <= uvs_pkg::clamp_unit(uvs_pkg::round_away(40'(px_reg), 14));
            ny_reg <= uvs_pkg::clamp_unit(uvs_pkg::round_away(40'(py_reg), 14));
            nz_reg <= cos_col;
        end
        else if (cmd.load_pole)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= cmd.south ? -uvs_pkg::UNIT_Q14 : uvs_pkg::UNIT_Q14;
        end
        if (cmd.mul_pos)
        begin
            qx_reg <= 33'(nx_reg) * 33'(diam_s);
            qy_reg <= 33'(ny_reg) * 33'(diam_s);
            qz_reg <= 33'(nz_reg) * 33'(diam_s);
        end
        if (cmd.emit)
        begin
            if (cmd.emit_tri)
            begin
                kind_reg     <= uvs_pkg::KIND_TRI;
                pos_x_reg    <= '0;
                pos_y_reg    <= '0;
                pos_z_reg    <= '0;
                norm_x_reg   <= '0;
                norm_y_reg   <= '0;
                norm_z_reg   <= '0;
                corner_a_reg <= corner_a_op;
                corner_b_reg <= corner_b_op;
                corner_c_reg <= corner_c_op;
                done_reg     <= cmd.last;
            end
            else
            begin
                kind_reg     <= uvs_pkg::KIND_VERTEX;
                pos_x_reg    <= rx[16:0];
                pos_y_reg    <= ry[16:0];
                pos_z_reg    <= rz[16:0];
                norm_x_reg   <= nx_reg;
                norm_y_reg   <= ny_reg;
                norm_z_reg   <= nz_reg;
                corner_a_reg <= '0;
                corner_b_reg <= '0;
                corner_c_reg <= '0;
                done_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.emit)
            valid_reg <= 1'b1;
        else if (elem.ready)
            valid_reg <= 1'b0;
    end

    assign stat.div_done  = lon_div_done && col_div_done;
    assign stat.rot_done  = lon_rot_done && col_rot_done;
    assign stat.slot_free = !valid_reg || elem.ready;

    assign elem.valid        = valid_reg;
    assign elem.element_kind = kind_reg;
    assign elem.pos_x        = pos_x_reg;
    assign elem.pos_y        = pos_y_reg;
    assign elem.pos_z        = pos_z_reg;
    assign elem.norm_x       = norm_x_reg;
    assign elem.norm_y       = norm_y_reg;
    assign elem.norm_z       = norm_z_reg;
    assign elem.corner_a     = corner_a_reg;
    assign elem.corner_b     = corner_b_reg;
    assign elem.corner_c     = corner_c_reg;
    assign elem.mesh_done    = done_reg;

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> elem.valid)
        else $error("emitted element not presented");

    a_vertex_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (elem.valid && elem.element_kind == uvs_pkg::KIND_VERTEX) |-> !elem.mesh_done)
        else $error("vertex flagged as end of mesh");

endmodule

FILE: src/uvs_ctrl.sv
// Sequencer: configuration registers, mesh position counters and the state machine
// that drives the vertex datapath. Depends on uvs_pkg and uvs_if.
module uvs_ctrl #(
    parameter int MAX_DIVISIONS = 256,
    localparam int DIV_W        = $clog2(MAX_DIVISIONS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    uvs_req_if.sink           req,
    uvs_cfg_if.sink           cfg,
    output uvs_pkg::dp_cmd_t  cmd,
    input  uvs_pkg::dp_stat_t stat,
    output logic [DIV_W-1:0]  col_op,
    output logic [DIV_W-1:0]  band_op,
    output logic [DIV_W-1:0]  lon_op,
    output logic [DIV_W-1:0]  lat_op,
    output logic [15:0]       diameter_op,
    output logic [15:0]       corner_a_op,
    output logic [15:0]       corner_b_op,
    output logic [15:0]       corner_c_op
);
    localparam int COL_W = DIV_W + 1;
    localparam int CMP_W = (DIV_W > 9) ? DIV_W : 9;
    localparam int LV_W  = 2 * DIV_W + 1;

    logic [15:0] diameter_reg;
    logic [8:0]  lat_div_reg;
    logic [8:0]  lon_div_reg;

    uvs_pkg::state_t state_reg, state_next;
    uvs_pkg::phase_t phase_reg, phase_next;
    logic [DIV_W-1:0] band_reg, band_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [15:0]      ring_reg, ring_next;

    logic        tri_reg;
    logic        last_reg, last_next;
    logic [15:0] a_reg, a_next;
    logic [15:0] b_reg, b_next;
    logic [15:0] c_reg, c_next;

    logic             accept;
    logic [DIV_W-1:0] lat_n, lon_n;
    logic [CMP_W-1:0] lat_wide, lon_wide;
    logic [15:0]      last_vertex;
    logic [LV_W-1:0]  lv_full;

    uvs_pkg::phase_t  eph;
    logic [DIV_W-1:0] eband;
    logic [COL_W-1:0] ecol;
    logic [15:0]      ering;

    // clamped division counts
    always_comb
    begin
        lat_wide = CMP_W'(lat_div_reg);
        lon_wide = CMP_W'(lon_div_reg);
        if (lat_wide < CMP_W'(2))
            lat_n = DIV_W'(2);
        else if (lat_wide > CMP_W'(MAX_DIVISIONS))
            lat_n = DIV_W'(MAX_DIVISIONS);
        else
            lat_n = lat_wide[DIV_W-1:0];
        if (lon_wide < CMP_W'(3))
            lon_n = DIV_W'(3);
        else if (lon_wide > CMP_W'(MAX_DIVISIONS))
            lon_n = DIV_W'(MAX_DIVISIONS);
        else
            lon_n = lon_wide[DIV_W-1:0];
        lv_full     = LV_W'(lat_n - 1'b1) * LV_W'(lon_n);
        last_vertex = 16'(lv_full + 1'b1);
    end

    assign accept = req.valid && req.ready;

    // restart takes effect before the item is stepped
    assign eph   = req.restart ? uvs_pkg::PH_NORTH : phase_reg;
    assign eband = req.restart ? '0 : band_reg;
    assign ecol  = req.restart ? '0 : col_reg;
    assign ering = req.restart ? 16'd1 : ring_reg;

    // mesh stepping
    always_comb
    begin
        logic [COL_W:0]   col_inc;
        logic [COL_W:0]   lon_cmp;
        logic [COL_W:0]   lon2_cmp;
        logic [DIV_W:0]   band_inc;
        logic             cap;
        logic             south;
        logic             row_end;
        logic [DIV_W-1:0] qcol;
        logic [DIV_W-1:0] nxt;
        logic [15:0]      p16, q16, r16, t16;

        phase_next = eph;
        band_next  = eband;
        col_next   = ecol;
        ring_next  = ering;
        a_next     = '0;
        b_next     = '0;
        c_next     = '0;
        last_next  = 1'b0;

        col_inc  = (COL_W + 1)'(ecol) + 1'b1;
        lon_cmp  = (COL_W + 1)'(lon_n);
        lon2_cmp = (COL_W + 1)'({lon_n, 1'b0});
        band_inc = (DIV_W + 1)'(eband) + 1'b1;
        cap      = (eband == '0) || (eband >= lat_n - 1'b1);
        south    = eband != '0;
        row_end  = col_inc >= lon_cmp;
        qcol     = ecol[COL_W-1:1];
        nxt      = '0;
        p16      = '0;
        q16      = '0;
        r16      = '0;
        t16      = '0;

        case (eph)
            uvs_pkg::PH_NORTH:
            begin
                phase_next = uvs_pkg::PH_RING;
                band_next  = DIV_W'(1);
                col_next   = '0;
            end
            uvs_pkg::PH_RING:
            begin
                if (row_end)
                begin
                    col_next  = '0;
                    band_next = band_inc[DIV_W-1:0];
                    if (band_inc >= (DIV_W + 1)'(lat_n))
                        phase_next = uvs_pkg::PH_SOUTH;
                end
                else
                    col_next = col_inc[COL_W-1:0];
            end
            uvs_pkg::PH_SOUTH:
            begin
                phase_next = uvs_pkg::PH_TRI;
                band_next  = '0;
                col_next   = '0;
                ring_next  = 16'd1;
            end
            uvs_pkg::PH_TRI:
            begin
                if (cap)
                begin
                    nxt = row_end ? '0 : col_inc[DIV_W-1:0];
                    p16 = 16'(nxt) + ering;
                    q16 = 16'(ecol) + ering;
                    if (!south)
                    begin
                        a_next = q16;
                        b_next = p16;
                        c_next = '0;
                    end
                    else
                    begin
                        a_next    = p16;
                        b_next    = q16;
                        c_next    = last_vertex;
                        last_next = row_end;
                    end
                    col_next = col_inc[COL_W-1:0];
                    if (row_end)
                    begin
                        if (south)
                        begin
                            // end of mesh: back to the north pole
                            phase_next = uvs_pkg::PH_NORTH;
                            band_next  = '0;
                            col_next   = '0;
                            ring_next  = 16'd1;
                        end
                        else
                        begin
                            col_next  = '0;
                            band_next = band_inc[DIV_W-1:0];
                        end
                    end
                end
                else
                begin
                    nxt = ((DIV_W + 1)'(qcol) + 1'b1 >= (DIV_W + 1)'(lon_n))
                          ? '0 : DIV_W'(qcol + 1'b1);
                    p16 = 16'(nxt) + ering;
                    q16 = 16'(qcol) + ering;
                    r16 = q16 + 16'(lon_n);
                    t16 = p16 + 16'(lon_n);
                    if (!ecol[0])
                    begin
                        a_next = p16;
                        b_next = q16;
                        c_next = r16;
                    end
                    else
                    begin
                        a_next = r16;
                        b_next = t16;
                        c_next = p16;
                    end
                    if (col_inc >= lon2_cmp)
                    begin
                        col_next  = '0;
                        band_next = band_inc[DIV_W-1:0];
                        ring_next = ering + 16'(lon_n);
                    end
                    else
                        col_next = col_inc[COL_W-1:0];
                end
            end
            default:
            begin
                phase_next = uvs_pkg::PH_NORTH;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            uvs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (eph == uvs_pkg::PH_RING)
                        state_next = uvs_pkg::ST_DIV;
                    else if (eph == uvs_pkg::PH_TRI)
                        state_next = uvs_pkg::ST_EMIT;
                    else
                        state_next = uvs_pkg::ST_MULP;
                end
            end
            uvs_pkg::ST_DIV:
                if (stat.div_done)
                    state_next = uvs_pkg::ST_ROT;
            uvs_pkg::ST_ROT:
                if (stat.rot_done)
                    state_next = uvs_pkg::ST_MULN;
            uvs_pkg::ST_MULN:
                state_next = uvs_pkg::ST_NORM;
            uvs_pkg::ST_NORM:
                state_next = uvs_pkg::ST_MULP;
            uvs_pkg::ST_MULP:
                state_next = uvs_pkg::ST_EMIT;
            uvs_pkg::ST_EMIT:
                if (stat.slot_free)
                    state_next = uvs_pkg::ST_IDLE;
            default:
                state_next = uvs_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready     = state_reg == uvs_pkg::ST_IDLE;
        cmd.div_start = accept && eph == uvs_pkg::PH_RING;
        cmd.load_pole = accept && (eph == uvs_pkg::PH_NORTH || eph == uvs_pkg::PH_SOUTH);
        cmd.south     = eph == uvs_pkg::PH_SOUTH;
        cmd.rot_start = state_reg == uvs_pkg::ST_DIV && stat.div_done;
        cmd.mul_norm  = state_reg == uvs_pkg::ST_MULN;
        cmd.load_norm = state_reg == uvs_pkg::ST_NORM;
        cmd.mul_pos   = state_reg == uvs_pkg::ST_MULP;
        cmd.emit      = state_reg == uvs_pkg::ST_EMIT && stat.slot_free;
        cmd.emit_tri  = tri_reg;
        cmd.last      = last_reg;
    end

    assign cfg.ready   = 1'b1;
    assign col_op      = ecol[DIV_W-1:0];
    assign band_op     = eband;
    assign lon_op      = lon_n;
    assign lat_op      = lat_n;
    assign diameter_op = diameter_reg;
    assign corner_a_op = a_reg;
    assign corner_b_op = b_reg;
    assign corner_c_op = c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diameter_reg <= uvs_pkg::DIAMETER_RESET;
            lat_div_reg  <= uvs_pkg::LAT_DIV_RESET;
            lon_div_reg  <= uvs_pkg::LON_DIV_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                uvs_pkg::REG_DIAMETER: diameter_reg <= cfg.data;
                uvs_pkg::REG_LAT_DIV:  lat_div_reg  <= cfg.data[8:0];
                uvs_pkg::REG_LON_DIV:  lon_div_reg  <= cfg.data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uvs_pkg::ST_IDLE;
            phase_reg <= uvs_pkg::PH_NORTH;
            band_reg  <= '0;
            col_reg   <= '0;
            ring_reg  <= 16'd1;
            tri_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                band_reg  <= band_next;
                col_reg   <= col_next;
                ring_reg  <= ring_next;
                tri_reg   <= eph == uvs_pkg::PH_TRI;
                last_reg  <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != uvs_pkg::ST_IDLE)
        else $error("accepted item did not start work");

    a_restart_north: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.restart) |=> phase_reg == uvs_pkg::PH_RING)
        else $error("restart did not emit the north pole");

endmodule
